// File: rtl/ljpe_pkg.sv
// ----------------------------------------------------------------------------
// ljpe_pkg
// Shared constants, types and codes for the Lennard-Jones pair energy block.
// ----------------------------------------------------------------------------
package ljpe_pkg;

  localparam int PARTICLE_COUNT = 1024;
  localparam int IDX_W          = 10;
  localparam int E_W            = 48;

  localparam logic [E_W-1:0] E_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [E_W-1:0] E_MIN = 48'h8000_0000_0000;

  localparam logic [63:0] ONE32 = 64'h0000_0001_0000_0000;
  localparam logic [63:0] CAP62 = 64'h4000_0000_0000_0000;
  localparam logic [63:0] FAR_U = 64'h8000_0000_0000_0000;

  typedef enum logic [1:0] {
    CFG_WRAP   = 2'd0,
    CFG_YMIN   = 2'd1,
    CFG_YMAX   = 2'd2,
    CFG_HEIGHT = 2'd3
  } cfg_reg_t;

  typedef enum logic [4:0] {
    S_IDLE, S_WRAP, S_DIFF, S_SQX, S_SQY, S_USUM, S_UCHK, S_DIV, S_MUL, S_MCAP,
    S_RDA, S_WRA, S_RDB, S_WRB, S_RDV, S_GETV, S_DONE
  } state_t;

  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [E_W-1:0]   wr_data;
  } store_ctl_t;

endpackage

// File: rtl/ljpe_mul.sv
// ----------------------------------------------------------------------------
// ljpe_mul
// Shared 32x32 unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module ljpe_mul (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] prod
);

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

// File: rtl/ljpe_div.sv
// ----------------------------------------------------------------------------
// ljpe_div
// Bit-serial reciprocal: floor((2^64 - 1) / d), one quotient bit a cycle.
// ----------------------------------------------------------------------------
module ljpe_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] divisor,
  output logic        done,
  output logic [63:0] quotient
);

  logic        busy;
  logic [5:0]  cnt;
  logic [63:0] rem;
  logic [63:0] dvr;
  logic [64:0] trial;
  logic        fits;

  // dividend is all ones, so shift in a one every step
  always_comb begin
    trial = {rem, 1'b1};
    fits  = trial >= {1'b0, dvr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvr      <= divisor;
      quotient <= '0;
    end else if (busy) begin
      rem      <= fits ? 64'(trial - {1'b0, dvr}) : trial[63:0];
      quotient <= {quotient[62:0], fits};
    end
  end

endmodule

// File: rtl/ljpe_store.sv
// ----------------------------------------------------------------------------
// ljpe_store
// Energy store: one write and one registered read a cycle, cleared by a sweep
// after reset.
// ----------------------------------------------------------------------------
module ljpe_store (
  input  logic                         clk,
  input  logic                         rst,
  input  ljpe_pkg::store_ctl_t         ctl,
  output logic [ljpe_pkg::E_W-1:0]     rdata,
  output logic                         busy
);

  logic [ljpe_pkg::E_W-1:0]   mem [ljpe_pkg::PARTICLE_COUNT];
  logic [ljpe_pkg::IDX_W-1:0] clr_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b1;
      clr_idx <= '0;
    end else if (busy) begin
      clr_idx <= clr_idx + 1'b1;
      if (clr_idx == ljpe_pkg::IDX_W'(ljpe_pkg::PARTICLE_COUNT - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_idx] <= '0;
    end else if (ctl.wr_en) begin
      mem[ctl.wr_addr] <= ctl.wr_data;
    end
    if (ctl.rd_en) begin
      rdata <= mem[ctl.rd_addr];
    end
  end

endmodule

// File: rtl/lennard_jones_pair_energy_accumulator.sv
// ----------------------------------------------------------------------------
// lennard_jones_pair_energy_accumulator
// Reduced Lennard-Jones 12-6 pair energy, accumulated per particle.
// ----------------------------------------------------------------------------
// An accumulate word runs through setup and squaring (wrap, difference, the
// two squares, their sum and a check), the bit-serial reciprocal divider (one
// quotient bit a cycle, 64 bits), three 64x64 products of four partial
// products each on the one shared 32x32 multiplier, read-modify-write on the
// energy store and the load of the output register; a zero distance skips
// the divider and the products. A read word reads its entry, clears it and
// loads the output register. One word is in flight at a time: a new word is
// taken only once the block is back in idle; a finished result waits in the
// output register while the next word is taken. After reset the store is
// cleared by a sweep of all 1024 entries during which in_stall stays high; configuration writes are taken at any time.
module lennard_jones_pair_energy_accumulator (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               kind,
  input  logic [9:0]         index_a,
  input  logic [9:0]         index_b,
  input  logic signed [31:0] pos_a_x,
  input  logic signed [31:0] pos_a_y,
  input  logic signed [31:0] pos_b_x,
  input  logic signed [31:0] pos_b_y,
  input  logic               a_is_wall,
  input  logic               b_is_wall,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [47:0] energy_value,
  output logic signed [47:0] pair_term,
  output logic               saturated
);

  ljpe_pkg::state_t state, state_next;

  // configuration
  logic        wrap_y_mode;
  logic [31:0] y_min;
  logic [31:0] y_max;
  logic [30:0] cell_height;

  // latched word
  logic        kind_r;
  logic [9:0]  ia;
  logic [9:0]  ib;
  logic [31:0] ax, ay, bx, by;
  logic        awall, bwall;

  // datapath
  logic [36:0]  by_w;
  logic [30:0]  mx, my;
  logic         far;
  logic [63:0]  u;
  logic [63:0]  ma, mb;
  logic [127:0] acc;
  logic [2:0]   mcnt;
  logic [1:0]   mphase;
  logic         pos;
  logic [47:0]  term;
  logic         sat;
  logic [47:0]  value;

  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic        div_start, div_done;
  logic [63:0] quotient;

  ljpe_pkg::store_ctl_t st_ctl;
  logic [47:0]          st_rdata;
  logic                 st_busy;

  ljpe_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod(prod));

  ljpe_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .divisor(u),
    .done(div_done), .quotient(quotient)
  );

  ljpe_store u_store (
    .clk(clk), .rst(rst), .ctl(st_ctl), .rdata(st_rdata), .busy(st_busy)
  );

  logic accept;
  assign cfg_ready = 1'b1;
  assign in_stall  = st_busy || (state != ljpe_pkg::S_IDLE);
  assign accept    = in_valid && !in_stall;

  logic in_a, in_b;
  assign in_a = 32'(ia) < ljpe_pkg::PARTICLE_COUNT;
  assign in_b = 32'(ib) < ljpe_pkg::PARTICLE_COUNT;

  always_ff @(posedge clk) begin
    if (rst) begin
      wrap_y_mode <= 1'b0;
      y_min       <= '0;
      y_max       <= '0;
      cell_height <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (ljpe_pkg::cfg_reg_t'(cfg_index))
        ljpe_pkg::CFG_WRAP:   wrap_y_mode <= cfg_data[0];
        ljpe_pkg::CFG_YMIN:   y_min       <= cfg_data;
        ljpe_pkg::CFG_YMAX:   y_max       <= cfg_data;
        ljpe_pkg::CFG_HEIGHT: cell_height <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // periodic band for the second particle's y
  logic [36:0] band_lo, band_hi, by_x, by_wrap;
  always_comb begin
    band_lo = {{5{y_min[31]}}, y_min} - {7'b0, cell_height[30:1]};
    band_hi = {{5{y_max[31]}}, y_max} + {7'b0, cell_height[30:1]};
    by_x    = {{5{by[31]}}, by};
    by_wrap = by_x;
    if (wrap_y_mode) begin
      if ($signed(by_x) > $signed(band_hi)) begin
        by_wrap = band_lo + (by_x - band_hi);
      end else if ($signed(by_x) < $signed(band_lo)) begin
        by_wrap = band_hi - (band_lo - by_x);
      end
    end
  end

  logic [37:0] dx, dy, adx, ady;
  always_comb begin
    dx  = {{6{ax[31]}}, ax} - {{6{bx[31]}}, bx};
    dy  = {{6{ay[31]}}, ay} - {by_w[36], by_w};
    adx = dx[37] ? 38'(-dx) : dx;
    ady = dy[37] ? 38'(-dy) : dy;
  end

  // 64x64 product: partial products in order ll, lh, hl, hh
  logic [127:0] pp;
  always_comb begin
    mul_a = {ma[31:0]};
    mul_b = {mb[31:0]};
    unique case (state)
      ljpe_pkg::S_SQX: begin
        mul_a = {1'b0, mx};
        mul_b = {1'b0, mx};
      end
      ljpe_pkg::S_SQY: begin
        mul_a = {1'b0, my};
        mul_b = {1'b0, my};
      end
      default: begin
        mul_a = mcnt[1] ? ma[63:32] : ma[31:0];
        mul_b = mcnt[0] ? mb[63:32] : mb[31:0];
      end
    endcase
    case (mcnt)
      3'd1:    pp = {64'b0, prod};
      3'd2,
      3'd3:    pp = {32'b0, prod, 32'b0};
      default: pp = {prod, 64'b0};
    endcase
  end

  logic [63:0] mr, mr_cap;
  logic        mr_sat;
  logic [57:0] q;
  always_comb begin
    mr     = acc[95:32];
    mr_sat = (acc[127:96] != 32'b0) || (mr > ljpe_pkg::CAP62);
    mr_cap = mr_sat ? ljpe_pkg::CAP62 : mr;
    q      = mr_cap[63:6];
  end

  logic [48:0] sum;
  logic [47:0] sum_sat;
  logic        sum_ovf;
  always_comb begin
    sum     = {st_rdata[47], st_rdata} + {term[47], term};
    sum_ovf = sum[48] != sum[47];
    sum_sat = sum_ovf ? (sum[48] ? ljpe_pkg::E_MIN : ljpe_pkg::E_MAX) : sum[47:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ljpe_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  logic ld_out;
  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    ld_out     = 1'b0;
    st_ctl     = '0;
    unique case (state)
      ljpe_pkg::S_IDLE: begin
        if (accept) begin
          state_next = kind ? ljpe_pkg::S_RDV : ljpe_pkg::S_WRAP;
        end
      end
      ljpe_pkg::S_WRAP: state_next = ljpe_pkg::S_DIFF;
      ljpe_pkg::S_DIFF: state_next = ljpe_pkg::S_SQX;
      ljpe_pkg::S_SQX:  state_next = ljpe_pkg::S_SQY;
      ljpe_pkg::S_SQY:  state_next = ljpe_pkg::S_USUM;
      ljpe_pkg::S_USUM: state_next = ljpe_pkg::S_UCHK;
      ljpe_pkg::S_UCHK: begin
        if (u == 64'b0) begin
          state_next = ljpe_pkg::S_RDA;
        end else begin
          div_start  = 1'b1;
          state_next = ljpe_pkg::S_DIV;
        end
      end
      ljpe_pkg::S_DIV: begin
        if (div_done) state_next = ljpe_pkg::S_MUL;
      end
      ljpe_pkg::S_MUL: begin
        if (mcnt == 3'd4) state_next = ljpe_pkg::S_MCAP;
      end
      ljpe_pkg::S_MCAP: begin
        state_next = (mphase == 2'd2) ? ljpe_pkg::S_RDA : ljpe_pkg::S_MUL;
      end
      ljpe_pkg::S_RDA: begin
        st_ctl.rd_en   = 1'b1;
        st_ctl.rd_addr = ia;
        state_next     = ljpe_pkg::S_WRA;
      end
      ljpe_pkg::S_WRA: begin
        st_ctl.wr_en   = !awall && in_a;
        st_ctl.wr_addr = ia;
        st_ctl.wr_data = sum_sat;
        state_next     = ljpe_pkg::S_RDB;
      end
      ljpe_pkg::S_RDB: begin
        st_ctl.rd_en   = 1'b1;
        st_ctl.rd_addr = ib;
        state_next     = ljpe_pkg::S_WRB;
      end
      ljpe_pkg::S_WRB: begin
        st_ctl.wr_en   = !bwall && in_b;
        st_ctl.wr_addr = ib;
        st_ctl.wr_data = sum_sat;
        state_next     = ljpe_pkg::S_RDV;
      end
      ljpe_pkg::S_RDV: begin
        st_ctl.rd_en   = 1'b1;
        st_ctl.rd_addr = ia;
        state_next     = ljpe_pkg::S_GETV;
      end
      ljpe_pkg::S_GETV: begin
        // a read word clears its entry
        st_ctl.wr_en   = kind_r && in_a;
        st_ctl.wr_addr = ia;
        st_ctl.wr_data = '0;
        state_next     = ljpe_pkg::S_DONE;
      end
      ljpe_pkg::S_DONE: begin
        if (!out_valid || !out_stall) begin
          ld_out     = 1'b1;
          state_next = ljpe_pkg::S_IDLE;
        end
      end
      default: state_next = ljpe_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= kind;
      ia     <= index_a;
      ib     <= index_b;
      ax     <= pos_a_x;
      ay     <= pos_a_y;
      bx     <= pos_b_x;
      by     <= pos_b_y;
      awall  <= a_is_wall;
      bwall  <= b_is_wall;
      term   <= '0;
      sat    <= 1'b0;
    end
    unique case (state)
      ljpe_pkg::S_WRAP: by_w <= by_wrap;
      ljpe_pkg::S_DIFF: begin
        mx  <= adx[30:0];
        my  <= ady[30:0];
        far <= (adx[37:31] != 7'b0) || (ady[37:31] != 7'b0);
      end
      ljpe_pkg::S_SQY:  u <= prod;
      ljpe_pkg::S_USUM: u <= far ? ljpe_pkg::FAR_U : u + prod;
      ljpe_pkg::S_UCHK: begin
        if (u == 64'b0) begin
          term <= ljpe_pkg::E_MAX;
          sat  <= 1'b1;
        end
        mphase <= 2'd0;
      end
      ljpe_pkg::S_DIV: begin
        ma   <= quotient;
        mb   <= quotient;
        mcnt <= '0;
        acc  <= '0;
      end
      ljpe_pkg::S_MUL: begin
        mcnt <= mcnt + 3'd1;
        if (mcnt != 3'd0) acc <= acc + pp;
      end
      ljpe_pkg::S_MCAP: begin
        if (mr_sat) sat <= 1'b1;
        mcnt   <= '0;
        acc    <= '0;
        mphase <= mphase + 2'd1;
        case (mphase)
          2'd0: begin
            ma <= mr_cap;
            mb <= ma;
          end
          2'd1: begin
            ma  <= mr_cap;
            pos <= mr_cap >= ljpe_pkg::ONE32;
            mb  <= (mr_cap >= ljpe_pkg::ONE32) ? mr_cap - ljpe_pkg::ONE32
                                               : ljpe_pkg::ONE32 - mr_cap;
          end
          default: begin
            if (pos) begin
              if (q[57:47] != 11'b0) begin
                term <= ljpe_pkg::E_MAX;
                sat  <= 1'b1;
              end else begin
                term <= q[47:0];
              end
            end else begin
              term <= 48'(-q[47:0]);
            end
          end
        endcase
      end
      ljpe_pkg::S_WRA: begin
        if (!awall && in_a && sum_ovf) sat <= 1'b1;
      end
      ljpe_pkg::S_WRB: begin
        if (!bwall && in_b && sum_ovf) sat <= 1'b1;
      end
      ljpe_pkg::S_GETV: value <= in_a ? st_rdata : '0;
      default: ;
    endcase
  end

  // output register parts the result from the next word
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ld_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_out) begin
      energy_value <= value;
      pair_term    <= term;
      saturated    <= sat;
    end
  end

  a_clear_blocks_input: assert property (@(posedge clk) disable iff (rst)
    st_busy |-> in_stall)
    else $error("word taken during store clear");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != ljpe_pkg::S_IDLE)
    else $error("accepted word did not start");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ljpe_pkg::S_DIV)
    else $error("divider finished outside its wait state");

  a_load_frees_out: assert property (@(posedge clk) disable iff (rst)
    ld_out |=> out_valid)
    else $error("result load lost");

endmodule
